### src/hlgbp_pkg.sv
// Package for the hybrid local/global branch predictor.
// Holds table sizes, field widths, command codes, the sequencer state type,
// the counter training function and the address function; it depends on nothing else.
package hlgbp_pkg;

    localparam int ADDR_BITS        = 10;
    localparam int GLOBAL_HIST_BITS = 12;
    localparam int LOCAL_HIST_BITS  = 10;

    localparam int BRANCH_IDX_W = 10;
    localparam int VISIT_W      = 6;
    localparam int CTR_W        = 3;
    localparam int WARMUP_W     = 6;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 8;
    localparam int ADDR_ENTRY_W = VISIT_W + LOCAL_HIST_BITS;

    localparam int CLR_BITS_AG = (ADDR_BITS > GLOBAL_HIST_BITS) ? ADDR_BITS : GLOBAL_HIST_BITS;
    localparam int CLR_BITS    = (CLR_BITS_AG > LOCAL_HIST_BITS) ? CLR_BITS_AG : LOCAL_HIST_BITS;

    localparam logic [VISIT_W-1:0]  VISIT_MAX     = '1;
    localparam logic [CTR_W-1:0]    CTR_MAX       = 3'd7;
    localparam logic [CTR_W-1:0]    CTR_MIN       = 3'd0;
    localparam logic [CTR_W-1:0]    CTR_RESET     = 3'd3;
    localparam logic [CTR_W-1:0]    CTR_TAKEN_MIN = 3'd4;
    localparam logic [WARMUP_W-1:0] WARMUP_RESET  = 6'd10;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_LCTR  = 4'b0100,
        S_WB    = 4'b1000
    } t_state;

    function automatic logic [CTR_W-1:0] f_train(input logic [CTR_W-1:0] ctr, input logic up);
        logic [CTR_W-1:0] res;
        res = ctr;
        if (up) begin
            if (ctr != CTR_MAX) res = ctr + CTR_W'(1);
        end else begin
            if (ctr != CTR_MIN) res = ctr - CTR_W'(1);
        end
        return res;
    endfunction

    function automatic logic [ADDR_BITS-1:0] f_addr(input logic [BRANCH_IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[ADDR_BITS-1:0];
    endfunction

endpackage

### src/hlgbp_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds while no read is issued; no dependencies.
module hlgbp_ram #(
    parameter int WIDTH = 8,
    parameter int ABITS = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [ABITS-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [ABITS-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [2**ABITS];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/hybrid_local_global_branch_predictor_unit.sv
// Top level of the hybrid local/global branch predictor.
// An accepted item reads the per-address and global counter tables, then the local counter
// table in S_LCTR; S_WB, once the output is free, registers the result and writes back updates.
// A new item is taken only after S_WB, so a stalled output register holds the flow.
// Reset: synchronous; then a clearing sweep over 2**CLR_BITS (4096) indices runs with tready low.
// Uses hlgbp_pkg and hlgbp_ram.
module hybrid_local_global_branch_predictor_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [hlgbp_pkg::WARMUP_W-1:0]       i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [9:0] branch_index, [10] taken, [15:11] zero
    input  logic [hlgbp_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] cmd
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] predict_taken, [7:1] zero
    output logic [hlgbp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [0] used_global
    output logic                                 m_axis_tuser
);
    import hlgbp_pkg::*;

    t_state                      r_state, n_state;
    logic [CLR_BITS-1:0]         r_clr_idx;
    logic [WARMUP_W-1:0]         r_warmup;
    logic [GLOBAL_HIST_BITS-1:0] r_ghist;
    logic [ADDR_BITS-1:0]        r_addr;
    logic                        r_cmd;
    logic                        r_taken;
    logic                        r_out_valid;
    logic                        r_out_pred;
    logic                        r_out_glob;

    logic                        accept;
    logic                        wb_go;
    logic                        do_update;
    logic                        clearing;
    logic [ADDR_ENTRY_W-1:0]     addr_rdata;
    logic [CTR_W-1:0]            gctr_rdata;
    logic [CTR_W-1:0]            lctr_rdata;
    logic [VISIT_W-1:0]          visit;
    logic [LOCAL_HIST_BITS-1:0]  lhist;
    logic [VISIT_W-1:0]          visit_next;
    logic [LOCAL_HIST_BITS-1:0]  lhist_next;
    logic [GLOBAL_HIST_BITS-1:0] ghist_next;
    logic                        use_global;
    logic                        pred;

    logic                        addr_we, gctr_we, lctr_we;
    logic [ADDR_BITS-1:0]        addr_waddr;
    logic [GLOBAL_HIST_BITS-1:0] gctr_waddr;
    logic [LOCAL_HIST_BITS-1:0]  lctr_waddr;
    logic [ADDR_ENTRY_W-1:0]     addr_wdata;
    logic [CTR_W-1:0]            gctr_wdata, lctr_wdata;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign wb_go         = (r_state == S_WB) && (!r_out_valid || m_axis_tready);
    assign do_update     = wb_go && (r_cmd == CMD_UPDATE);
    assign clearing      = (r_state == S_CLEAR);

    assign visit = addr_rdata[ADDR_ENTRY_W-1:LOCAL_HIST_BITS];
    assign lhist = addr_rdata[LOCAL_HIST_BITS-1:0];

    assign visit_next = (visit == VISIT_MAX) ? visit : visit + VISIT_W'(1);
    assign lhist_next = {lhist[LOCAL_HIST_BITS-2:0], r_taken};
    assign ghist_next = {r_taken, r_ghist[GLOBAL_HIST_BITS-1:1]};

    assign use_global = (visit < r_warmup);
    assign pred = use_global ? (gctr_rdata >= CTR_TAKEN_MIN) : (lctr_rdata >= CTR_TAKEN_MIN);

    always_comb begin
        if (clearing) begin
            addr_we    = 1'b1;
            gctr_we    = 1'b1;
            lctr_we    = 1'b1;
            addr_waddr = r_clr_idx[ADDR_BITS-1:0];
            gctr_waddr = r_clr_idx[GLOBAL_HIST_BITS-1:0];
            lctr_waddr = r_clr_idx[LOCAL_HIST_BITS-1:0];
            addr_wdata = '0;
            gctr_wdata = CTR_RESET;
            lctr_wdata = CTR_RESET;
        end else begin
            addr_we    = do_update;
            gctr_we    = do_update;
            lctr_we    = do_update;
            addr_waddr = r_addr;
            gctr_waddr = r_ghist;
            lctr_waddr = lhist;
            addr_wdata = {visit_next, lhist_next};
            gctr_wdata = f_train(gctr_rdata, r_taken);
            lctr_wdata = f_train(lctr_rdata, r_taken);
        end
    end

    hlgbp_ram #(.WIDTH(ADDR_ENTRY_W), .ABITS(ADDR_BITS)) u_addr_ram (
        .i_clk   (i_clk),
        .i_we    (addr_we),
        .i_waddr (addr_waddr),
        .i_wdata (addr_wdata),
        .i_re    (accept),
        .i_raddr (f_addr(s_axis_tdata[BRANCH_IDX_W-1:0])),
        .o_rdata (addr_rdata)
    );

    hlgbp_ram #(.WIDTH(CTR_W), .ABITS(GLOBAL_HIST_BITS)) u_gctr_ram (
        .i_clk   (i_clk),
        .i_we    (gctr_we),
        .i_waddr (gctr_waddr),
        .i_wdata (gctr_wdata),
        .i_re    (accept),
        .i_raddr (r_ghist),
        .o_rdata (gctr_rdata)
    );

    hlgbp_ram #(.WIDTH(CTR_W), .ABITS(LOCAL_HIST_BITS)) u_lctr_ram (
        .i_clk   (i_clk),
        .i_we    (lctr_we),
        .i_waddr (lctr_waddr),
        .i_wdata (lctr_wdata),
        .i_re    (r_state == S_LCTR),
        .i_raddr (lhist),
        .o_rdata (lctr_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr_idx == '1) n_state = S_IDLE;
            S_IDLE:  if (accept) n_state = S_LCTR;
            S_LCTR:  n_state = S_WB;
            S_WB:    if (wb_go) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_warmup    <= WARMUP_RESET;
            r_ghist     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clearing) begin
                r_clr_idx <= r_clr_idx + CLR_BITS'(1);
            end
            if (i_cfg_we) begin
                r_warmup <= i_cfg_wdata;
            end
            if (do_update) begin
                r_ghist <= ghist_next;
            end
            if (wb_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr  <= f_addr(s_axis_tdata[BRANCH_IDX_W-1:0]);
            r_cmd   <= s_axis_tuser;
            r_taken <= s_axis_tdata[BRANCH_IDX_W];
        end
        if (wb_go) begin
            r_out_pred <= (r_cmd == CMD_UPDATE) ? 1'b0 : pred;
            r_out_glob <= (r_cmd == CMD_UPDATE) ? 1'b0 : use_global;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, r_out_pred};
    assign m_axis_tuser  = r_out_glob;

    a_accept_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_LCTR))
        else $error("accepted item did not advance to the local counter read");

    a_no_output_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !r_out_valid)
        else $error("result presented during the clearing sweep");

    a_update_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_update |=> (!m_axis_tdata[0] && !m_axis_tuser))
        else $error("update item produced a nonzero result");

    a_ghist_only_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !do_update |=> $stable(r_ghist))
        else $error("global history changed without an update");

    a_no_overwrite_of_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_pred)))
        else $error("pending result was lost or overwritten");

endmodule
